// ===== rtl/zcd_pkg.sv =====
// ----------------------------------------------------------------------------
// zcd_pkg
// Shared types, codes and constants of the zip central directory parser.
// ----------------------------------------------------------------------------
package zcd_pkg;

   // record framing
   localparam logic [31:0] CD_SIGNATURE = 32'h02014b50;
   localparam int          HDR_LEN      = 46;
   localparam logic [7:0]  HIGH_BYTE    = 8'h80;

   // byte positions inside the fixed record
   localparam logic [5:0] POS_SIG    = 6'd0;
   localparam logic [5:0] POS_FLAGS  = 6'd8;
   localparam logic [5:0] POS_METHOD = 6'd10;
   localparam logic [5:0] POS_CRC    = 6'd16;
   localparam logic [5:0] POS_PACKED = 6'd20;
   localparam logic [5:0] POS_PLAIN  = 6'd24;
   localparam logic [5:0] POS_NLEN   = 6'd28;
   localparam logic [5:0] POS_ELEN   = 6'd30;
   localparam logic [5:0] POS_CLEN   = 6'd32;
   localparam logic [5:0] POS_DISK   = 6'd34;
   localparam logic [5:0] POS_OFFSET = 6'd42;
   localparam logic [5:0] POS_LAST   = 6'(HDR_LEN - 1);

   // request commands
   localparam logic CMD_DATA   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_NAME   = 2'd0;
   localparam logic [1:0] KIND_ENTRY  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_TRUNC    = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_NAME     = 3'd3;
   localparam logic [2:0] ST_TRAILING = 3'd4;
   localparam logic [2:0] ST_SHORT    = 3'd5;

   // register indexes
   localparam logic [1:0] CSR_ENTRY_TOTAL = 2'd0;
   localparam logic [1:0] CSR_DIR_SIZE    = 2'd1;
   localparam logic [1:0] CSR_FOLD_SEL    = 2'd2;

   // name modes
   localparam logic [1:0] MODE_EXACT      = 2'd0;
   localparam logic [1:0] MODE_ASCII_ONLY = 2'd2;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_NAME,
      PHASE_SKIP
   } zcd_phase_type;

   typedef struct packed {
      logic [15:0] entry_total;
      logic [31:0] directory_size;
      logic [1:0]  fold_sel;
   } zcd_csr_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  name_byte;
      logic [15:0] entry_index;
      logic [15:0] entry_flags;
      logic [15:0] entry_method;
      logic [31:0] entry_crc;
      logic [31:0] packed_size;
      logic [31:0] plain_size;
      logic [31:0] header_offset;
      logic [2:0]  status;
      logic        last;
   } zcd_result_type;

   typedef struct packed {
      logic [1:0]     count;
      zcd_result_type first;
      zcd_result_type second;
   } zcd_push_type;

   // lower-case fold with backslash to slash
   function automatic logic [7:0] fold_byte(input logic [1:0] mode, input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (mode != MODE_EXACT) begin
         if (b == 8'h5C) begin
            r = 8'h2F;
         end else if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/zcd_if.sv =====
// ----------------------------------------------------------------------------
// zcd_req_if / zcd_rsp_if
// Valid/ready channels carrying requests and results of the parser.
// ----------------------------------------------------------------------------
interface zcd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source(output valid, command, data_byte, input ready);
   modport sink(input valid, command, data_byte, output ready);
endinterface

interface zcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  name_byte;
   logic [15:0] entry_index;
   logic [15:0] entry_flags;
   logic [15:0] entry_method;
   logic [31:0] entry_crc;
   logic [31:0] packed_size;
   logic [31:0] plain_size;
   logic [31:0] header_offset;
   logic [2:0]  status;
   logic        last;

   modport source(output valid, kind, name_byte, entry_index, entry_flags, entry_method,
                  entry_crc, packed_size, plain_size, header_offset, status, last,
                  input ready);
   modport sink(input valid, kind, name_byte, entry_index, entry_flags, entry_method,
                entry_crc, packed_size, plain_size, header_offset, status, last,
                output ready);
endinterface

// ===== rtl/zcd_core.sv =====
// ----------------------------------------------------------------------------
// zcd_core
// Configuration registers, parse state and the per-byte step logic. Each
// accepted request yields zero, one or two results for the result queue.
// ----------------------------------------------------------------------------
module zcd_core import zcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wr_data,
   input  logic         req_fire,
   input  logic         req_command,
   input  logic [7:0]   req_data_byte,
   output zcd_push_type push
);

   zcd_csr_type   csr_ff;
   zcd_phase_type phase_ff, phase_in;
   logic [31:0]   bp_ff, bp_in;
   logic [5:0]    hp_ff, hp_in;
   logic [15:0]   ed_ff, ed_in;
   logic [17:0]   vl_ff, vl_in;
   logic [15:0]   nl_ff, nl_in;
   logic [2:0]    err_ff, err_in;

   // fixed record fields
   logic [31:0] sig_ff;
   logic [15:0] flags_ff, method_ff;
   logic [31:0] crc_ff, packed_ff, plain_ff, offset_ff;
   logic [15:0] nlen_ff, elen_ff, clen_ff, disk_ff;
   logic [17:0] var_sum_ff;
   logic [16:0] vc_sum_ff;

   logic        is_data, hdr_start, all_done, start_short, range_bad, sig_bad, hdr_last;
   logic        name_bad;
   logic [33:0] rec_end;
   logic [15:0] nl_dec;
   logic [17:0] vl_dec;
   logic        raise, hdr_ok, name_ok, skip_end, hdr_adv, entry_emit, finish_entry;
   logic [2:0]  raise_code, finish_code;
   logic [17:0] entry_vl;
   zcd_result_type base_res, status_res, entry_res, name_res;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENTRY_TOTAL: csr_ff.entry_total    <= csr_wr_data[15:0];
            CSR_DIR_SIZE:    csr_ff.directory_size <= csr_wr_data;
            CSR_FOLD_SEL:    csr_ff.fold_sel       <= csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   // conditions of the current byte
   assign is_data     = req_fire && (req_command == CMD_DATA) && (err_ff == ST_OK);
   assign hdr_start   = (hp_ff == POS_SIG);
   assign hdr_last    = (hp_ff == POS_LAST);
   assign all_done    = (ed_ff >= csr_ff.entry_total);
   assign start_short = ({1'b0, bp_ff} + 33'(HDR_LEN)) > {1'b0, csr_ff.directory_size};
   assign rec_end     = {2'b00, bp_ff} + 34'd1 + 34'(var_sum_ff);
   assign range_bad   = (rec_end > {2'b00, csr_ff.directory_size}) || (disk_ff != 16'd0);
   assign sig_bad     = (sig_ff != CD_SIGNATURE);
   assign name_bad    = (req_data_byte == 8'd0) ||
                        ((csr_ff.fold_sel >= MODE_ASCII_ONLY) && (req_data_byte >= HIGH_BYTE));
   assign nl_dec      = nl_ff - 16'd1;
   assign vl_dec      = (vl_ff != 18'd0) ? vl_ff - 18'd1 : 18'd0;

   // step decode
   always_comb begin
      raise      = 1'b0;
      raise_code = ST_OK;
      hdr_ok     = 1'b0;
      name_ok    = 1'b0;
      skip_end   = 1'b0;
      if (is_data) begin
         unique case (phase_ff)
            PHASE_HEADER: begin
               if (hdr_start && all_done) begin
                  raise      = 1'b1;
                  raise_code = ST_TRAILING;
               end else if (hdr_start && start_short) begin
                  raise      = 1'b1;
                  raise_code = ST_TRUNC;
               end else if (hdr_last) begin
                  if (sig_bad) begin
                     raise      = 1'b1;
                     raise_code = ST_TRUNC;
                  end else if (range_bad) begin
                     raise      = 1'b1;
                     raise_code = ST_RANGE;
                  end else begin
                     hdr_ok = 1'b1;
                  end
               end
            end
            PHASE_NAME: begin
               if (name_bad) begin
                  raise      = 1'b1;
                  raise_code = ST_NAME;
               end else begin
                  name_ok = 1'b1;
               end
            end
            default: begin
               skip_end = (vl_dec == 18'd0);
            end
         endcase
      end
   end

   assign hdr_adv      = is_data && (phase_ff == PHASE_HEADER) && !raise;
   assign entry_emit   = (hdr_ok && (nlen_ff == 16'd0)) || (name_ok && (nl_dec == 16'd0));
   assign entry_vl     = hdr_ok ? 18'(vc_sum_ff) : vl_ff;
   assign finish_entry = (entry_emit && (entry_vl == 18'd0)) || skip_end;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PHASE_HEADER: begin
            if (hdr_ok) begin
               if (nlen_ff != 16'd0) begin
                  phase_in = PHASE_NAME;
               end else if (vc_sum_ff != 17'd0) begin
                  phase_in = PHASE_SKIP;
               end
            end
         end
         PHASE_NAME: begin
            if (name_ok && (nl_dec == 16'd0)) begin
               phase_in = (vl_ff != 18'd0) ? PHASE_SKIP : PHASE_HEADER;
            end
         end
         default: begin
            if (skip_end) begin
               phase_in = PHASE_HEADER;
            end
         end
      endcase
   end

   // counters and error state
   always_comb begin
      bp_in  = bp_ff;
      hp_in  = hp_ff;
      ed_in  = ed_ff;
      vl_in  = vl_ff;
      nl_in  = nl_ff;
      err_in = err_ff;
      if (raise) begin
         err_in = raise_code;
      end
      if (is_data && !raise) begin
         bp_in = bp_ff + 32'd1;
      end
      if (hdr_adv) begin
         hp_in = hdr_last ? POS_SIG : hp_ff + 6'd1;
      end
      if (hdr_ok) begin
         nl_in = nlen_ff;
         vl_in = 18'(vc_sum_ff);
      end
      if (name_ok) begin
         nl_in = nl_dec;
      end
      if (is_data && (phase_ff != PHASE_HEADER) && (phase_ff != PHASE_NAME)) begin
         vl_in = vl_dec;
      end
      if (finish_entry) begin
         ed_in = ed_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HEADER;
         bp_ff    <= '0;
         hp_ff    <= '0;
         ed_ff    <= '0;
         vl_ff    <= '0;
         nl_ff    <= '0;
         err_ff   <= ST_OK;
      end else begin
         phase_ff <= phase_in;
         bp_ff    <= bp_in;
         hp_ff    <= hp_in;
         ed_ff    <= ed_in;
         vl_ff    <= vl_in;
         nl_ff    <= nl_in;
         err_ff   <= err_in;
      end
   end

   // capture of fixed record bytes, little endian
   always_ff @(posedge clock) begin
      if (hdr_adv) begin
         unique case (hp_ff)
            POS_SIG:              sig_ff[7:0]      <= req_data_byte;
            POS_SIG + 6'd1:       sig_ff[15:8]     <= req_data_byte;
            POS_SIG + 6'd2:       sig_ff[23:16]    <= req_data_byte;
            POS_SIG + 6'd3:       sig_ff[31:24]    <= req_data_byte;
            POS_FLAGS:            flags_ff[7:0]    <= req_data_byte;
            POS_FLAGS + 6'd1:     flags_ff[15:8]   <= req_data_byte;
            POS_METHOD:           method_ff[7:0]   <= req_data_byte;
            POS_METHOD + 6'd1:    method_ff[15:8]  <= req_data_byte;
            POS_CRC:              crc_ff[7:0]      <= req_data_byte;
            POS_CRC + 6'd1:       crc_ff[15:8]     <= req_data_byte;
            POS_CRC + 6'd2:       crc_ff[23:16]    <= req_data_byte;
            POS_CRC + 6'd3:       crc_ff[31:24]    <= req_data_byte;
            POS_PACKED:           packed_ff[7:0]   <= req_data_byte;
            POS_PACKED + 6'd1:    packed_ff[15:8]  <= req_data_byte;
            POS_PACKED + 6'd2:    packed_ff[23:16] <= req_data_byte;
            POS_PACKED + 6'd3:    packed_ff[31:24] <= req_data_byte;
            POS_PLAIN:            plain_ff[7:0]    <= req_data_byte;
            POS_PLAIN + 6'd1:     plain_ff[15:8]   <= req_data_byte;
            POS_PLAIN + 6'd2:     plain_ff[23:16]  <= req_data_byte;
            POS_PLAIN + 6'd3:     plain_ff[31:24]  <= req_data_byte;
            POS_NLEN:             nlen_ff[7:0]     <= req_data_byte;
            POS_NLEN + 6'd1:      nlen_ff[15:8]    <= req_data_byte;
            POS_ELEN:             elen_ff[7:0]     <= req_data_byte;
            POS_ELEN + 6'd1:      elen_ff[15:8]    <= req_data_byte;
            POS_CLEN:             clen_ff[7:0]     <= req_data_byte;
            POS_CLEN + 6'd1:      clen_ff[15:8]    <= req_data_byte;
            POS_DISK:             disk_ff[7:0]     <= req_data_byte;
            POS_DISK + 6'd1:      disk_ff[15:8]    <= req_data_byte;
            POS_OFFSET:           offset_ff[7:0]   <= req_data_byte;
            POS_OFFSET + 6'd1:    offset_ff[15:8]  <= req_data_byte;
            POS_OFFSET + 6'd2:    offset_ff[23:16] <= req_data_byte;
            POS_OFFSET + 6'd3:    offset_ff[31:24] <= req_data_byte;
            default: ;
         endcase
      end
   end

   // variable length sums, settled long before the record's last byte
   always_ff @(posedge clock) begin
      var_sum_ff <= 18'(nlen_ff) + 18'(elen_ff) + 18'(clen_ff);
      vc_sum_ff  <= 17'(elen_ff) + 17'(clen_ff);
   end

   // finish status
   always_comb begin
      if (err_ff != ST_OK) begin
         finish_code = err_ff;
      end else if (all_done) begin
         finish_code = (bp_ff == csr_ff.directory_size) ? ST_OK : ST_TRAILING;
      end else begin
         finish_code = ST_SHORT;
      end
   end

   // result words
   always_comb begin
      base_res             = '0;
      base_res.entry_index = ed_ff;

      status_res        = base_res;
      status_res.kind   = KIND_STATUS;
      status_res.status = (req_command == CMD_FINISH) ? finish_code : raise_code;
      status_res.last   = 1'b1;

      entry_res              = base_res;
      entry_res.kind         = KIND_ENTRY;
      entry_res.entry_flags  = flags_ff;
      entry_res.entry_method = method_ff;
      entry_res.entry_crc    = crc_ff;
      entry_res.packed_size  = packed_ff;
      entry_res.plain_size   = plain_ff;
      // the offset's top byte arrives with the record's last byte
      entry_res.header_offset = (phase_ff == PHASE_HEADER) ?
                                {req_data_byte, offset_ff[23:0]} : offset_ff;
      entry_res.last         = 1'b1;

      name_res           = base_res;
      name_res.kind      = KIND_NAME;
      name_res.name_byte = fold_byte(csr_ff.fold_sel, req_data_byte);
      name_res.last      = (nl_dec != 16'd0);
   end

   // results toward the queue
   always_comb begin
      push.count  = 2'd0;
      push.first  = status_res;
      push.second = entry_res;
      priority if (req_fire && (req_command == CMD_FINISH)) begin
         push.count = 2'd1;
      end else if (raise) begin
         push.count = 2'd1;
      end else if (name_ok) begin
         push.first = name_res;
         push.count = (nl_dec == 16'd0) ? 2'd2 : 2'd1;
      end else if (entry_emit) begin
         push.first = entry_res;
         push.count = 2'd1;
      end else begin
         push.count = 2'd0;
      end
   end

endmodule

// ===== rtl/zcd_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// zcd_rsp_queue
// Small result queue: takes up to two results per cycle, hands out one.
// Parts the request side from a stalled result side.
// ----------------------------------------------------------------------------
module zcd_rsp_queue import zcd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  zcd_push_type   push,
   input  logic           pop,
   output zcd_result_type head,
   output logic           not_empty,
   output logic           has_room
);

   zcd_result_type         entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_next;
   logic                   do_pop;

   assign not_empty = (count_ff != '0);
   assign has_room  = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign head      = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;
   assign wr_next   = wr_ptr_ff + QUEUE_PTR_W'(1);

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push.count);
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== rtl/zip_central_directory_parser.sv =====
// Output: results are registered in the four-deep result queue and offered from it.
// Throughput: one request per cycle while the queue has room; the last name byte of an
// entry gives two results, which drain at one per cycle while rsp_if is ready.
// Reset: synchronous, active high; clears configuration, parse state and the queue.
// No clearing pass; requests are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// zip_central_directory_parser
// Walks a zip central directory one byte per request, checks each record,
// streams normalized name bytes and entry metadata, and reports status.
// ----------------------------------------------------------------------------
module zip_central_directory_parser import zcd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data,
   zcd_req_if.sink     req_if,
   zcd_rsp_if.source   rsp_if
);

   zcd_push_type   push;
   zcd_result_type head;
   logic           has_room, not_empty, req_fire;

   // request handshake
   assign req_if.ready = has_room;
   assign req_fire     = req_if.valid && has_room;

   zcd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_fire      (req_fire),
      .req_command   (req_if.command),
      .req_data_byte (req_if.data_byte),
      .push          (push)
   );

   zcd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_if.ready),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   // result channel
   assign rsp_if.valid         = not_empty;
   assign rsp_if.kind          = head.kind;
   assign rsp_if.name_byte     = head.name_byte;
   assign rsp_if.entry_index   = head.entry_index;
   assign rsp_if.entry_flags   = head.entry_flags;
   assign rsp_if.entry_method  = head.entry_method;
   assign rsp_if.entry_crc     = head.entry_crc;
   assign rsp_if.packed_size   = head.packed_size;
   assign rsp_if.plain_size    = head.plain_size;
   assign rsp_if.header_offset = head.header_offset;
   assign rsp_if.status        = head.status;
   assign rsp_if.last          = head.last;

endmodule

// ===== rtl/zcd_checker.sv =====
// ----------------------------------------------------------------------------
// zcd_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module zcd_checker import zcd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_command,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic       rsp_last
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // queue is empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // finish on an idle output shows its status next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_FINISH) && !rsp_valid
      |=> rsp_valid && (rsp_kind == KIND_STATUS))
      else $error("finish status missing");

   // a final name byte is followed at once by its entry record
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_NAME) && !rsp_last
      |=> rsp_valid && (rsp_kind == KIND_ENTRY))
      else $error("entry record does not follow name");

endmodule

bind zip_central_directory_parser zcd_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_command (req_if.command),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_kind    (rsp_if.kind),
   .rsp_last    (rsp_if.last)
);
